@@ design/set_assoc_cache_lru_controller_macros.svh @@
// assertion macros used by the checker file
`ifndef SET_ASSOC_CACHE_LRU_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SACL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sacl check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SACL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sacl check failed");

`endif

@@ design/sacl_pkg.sv @@
// types and codes shared by the cache tag controller
package sacl_pkg;

  typedef enum logic [1:0] {
    OK_FETCH = 2'd0,
    OK_WT    = 2'd1,
    OK_WB    = 2'd2,
    OK_DONE  = 2'd3
  } out_kind_e;

  typedef struct packed {
    logic        kind;
    logic [63:0] addr;
    logic [6:0]  bytes;
  } in_item_t;

  typedef struct packed {
    out_kind_e   out_kind;
    logic [63:0] lower_addr;
    logic [6:0]  lower_bytes;
    logic        hit;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_WT,
    ST_FETCH,
    ST_SCAN,
    ST_VIC,
    ST_WB,
    ST_FILL,
    ST_NEXT,
    ST_DONE
  } ctl_state_e;

  typedef struct packed {
    logic      clr_wr;
    logic      accept;
    logic      mem_rd;
    logic      eval;
    logic      emit;
    out_kind_e emit_kind;
    logic      scan_step;
    logic      vic_latch;
    logic      fill_wr;
    logic      next_part;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic is_hit;
    logic is_read;
    logic wb_mode;
    logic need_scan;
    logic scan_last;
    logic victim_dirty;
    logic has_second;
  } dp_stat_t;

endpackage

@@ design/sacl_ram.sv @@
// generic single-write, single-read ram with registered read data
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

@@ design/sacl_ctrl.sv @@
// sequencing state machine of the cache tag controller
module sacl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sacl_pkg::dp_stat_t  stat_i,
  output sacl_pkg::ctl_cmd_t  cmd_o
);
  import sacl_pkg::*;

  ctl_state_e state_q, state_d;
  logic       wt_needed;

  assign wt_needed = !stat_i.is_read && !stat_i.wb_mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_RD;
      ST_RD:    state_d = ST_EVAL;
      ST_EVAL: begin
        if (wt_needed) state_d = ST_WT;
        else if (stat_i.is_hit) state_d = ST_NEXT;
        else state_d = ST_FETCH;
      end
      ST_WT:    if (stat_i.out_free) state_d = ST_NEXT;
      ST_FETCH: begin
        if (stat_i.out_free) state_d = stat_i.need_scan ? ST_SCAN : ST_VIC;
      end
      ST_SCAN:  if (stat_i.scan_last) state_d = ST_VIC;
      ST_VIC:   state_d = stat_i.victim_dirty ? ST_WB : ST_FILL;
      ST_WB:    if (stat_i.out_free) state_d = ST_FILL;
      ST_FILL:  state_d = ST_NEXT;
      ST_NEXT:  state_d = stat_i.has_second ? ST_RD : ST_DONE;
      ST_DONE:  if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.emit_kind = OK_DONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_RD:   cmd_o.mem_rd = 1'b1;
      ST_EVAL: cmd_o.eval = 1'b1;
      ST_WT: begin
        cmd_o.emit      = stat_i.out_free;
        cmd_o.emit_kind = OK_WT;
      end
      ST_FETCH: begin
        cmd_o.emit      = stat_i.out_free;
        cmd_o.emit_kind = OK_FETCH;
      end
      ST_SCAN: cmd_o.scan_step = 1'b1;
      ST_VIC:  cmd_o.vic_latch = 1'b1;
      ST_WB: begin
        cmd_o.emit      = stat_i.out_free;
        cmd_o.emit_kind = OK_WB;
      end
      ST_FILL: cmd_o.fill_wr = 1'b1;
      ST_NEXT: cmd_o.next_part = stat_i.has_second;
      ST_DONE: begin
        cmd_o.emit      = stat_i.out_free;
        cmd_o.emit_kind = OK_DONE;
      end
      default: cmd_o.clr_wr = 1'b0;
    endcase
  end
endmodule

@@ design/sacl_dp.sv @@
// datapath: access split, tag compare, lru scan, row update, result register
module sacl_dp #(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sacl_pkg::in_item_t   in_item_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  sacl_pkg::ctl_cmd_t   cmd_i,
  output sacl_pkg::dp_stat_t   stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sacl_pkg::out_item_t  out_item_o,
  output logic                 mem_we_o,
  output logic [(SETS > 1 ? $clog2(SETS + 1) - 1 : 1) - 1 + (SETS > 1 ? 0 : 0):0] mem_waddr_o,
  output logic [WAYS*(STAMP_BITS + 2 + 64
                 - ($clog2(SETS + 1) - 1) - ($clog2(LINE_BYTES + 1) - 1))
                 + STAMP_BITS - 1:0] mem_wdata_o,
  output logic                 mem_re_o,
  output logic [(SETS > 1 ? $clog2(SETS + 1) - 1 : 1) - 1:0] mem_raddr_o,
  input  logic [WAYS*(STAMP_BITS + 2 + 64
                 - ($clog2(SETS + 1) - 1) - ($clog2(LINE_BYTES + 1) - 1))
                 + STAMP_BITS - 1:0] mem_rdata_i
);
  import sacl_pkg::*;

  localparam int B       = $clog2(LINE_BYTES + 1) - 1;
  localparam int S       = $clog2(SETS + 1) - 1;
  localparam int NSETS   = 1 << S;
  localparam int SET_W   = (S > 0) ? S : 1;
  localparam int TAG_W   = 64 - S - B;
  localparam int WAY_W   = STAMP_BITS + TAG_W + 2;
  localparam int ROW_W   = WAYS * WAY_W + STAMP_BITS;
  localparam int WIDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [63:0] OFF_MASK = (64'd1 << B) - 64'd1;
  localparam logic [63:0] SET_MASK = 64'(NSETS - 1);

  logic                  policy_q;
  logic                  kind_q;
  logic [63:0]           part_addr_q, addr2_q;
  logic [6:0]            part_len_q, len2_q;
  logic                  split_q, part_q, hit_acc_q;
  logic [WIDX_W-1:0]     scan_q, min_q, victim_q;
  logic [SET_W-1:0]      clr_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic [STAMP_BITS-1:0] stamp_a [WAYS];
  logic [TAG_W-1:0]      tag_a   [WAYS];
  logic [WAYS-1:0]       valid_v, dirty_v, hit_v;
  logic [STAMP_BITS-1:0] clock_v;
  logic [SET_W-1:0]      set_cur;
  logic [TAG_W-1:0]      tag_cur;
  logic [WIDX_W-1:0]     hit_way, inv_way, vic_sel;
  logic                  any_hit, any_inv;
  logic [ROW_W-1:0]      hit_row, fill_row, clr_row;
  logic [6:0]            len7, off7, first7;
  logic [7:0]            sum8;
  logic                  split_in;
  logic                  out_free;
  logic [63:0]           wb_addr;

  // row unpack
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      stamp_a[w] = mem_rdata_i[w*WAY_W +: STAMP_BITS];
      tag_a[w]   = mem_rdata_i[w*WAY_W + STAMP_BITS +: TAG_W];
      dirty_v[w] = mem_rdata_i[w*WAY_W + STAMP_BITS + TAG_W];
      valid_v[w] = mem_rdata_i[w*WAY_W + STAMP_BITS + TAG_W + 1];
    end
    clock_v = mem_rdata_i[WAYS*WAY_W +: STAMP_BITS];
  end

  assign set_cur = SET_W'((part_addr_q >> B) & SET_MASK);
  assign tag_cur = TAG_W'(part_addr_q >> (S + B));

  // lowest hitting way, highest invalid way
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    any_hit = 1'b0;
    any_inv = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit_v[w] = valid_v[w] && (tag_a[w] == tag_cur);
      if (hit_v[w]) begin
        hit_way = WIDX_W'(w);
        any_hit = 1'b1;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!valid_v[w]) begin
        inv_way = WIDX_W'(w);
        any_inv = 1'b1;
      end
    end
  end

  assign vic_sel = any_inv ? inv_way : min_q;

  always_comb begin
    hit_row = mem_rdata_i;
    hit_row[hit_way*WAY_W +: STAMP_BITS] = clock_v;
    if (!kind_q && policy_q) begin
      hit_row[hit_way*WAY_W + STAMP_BITS + TAG_W] = 1'b1;
    end
    hit_row[WAYS*WAY_W +: STAMP_BITS] = clock_v + STAMP_BITS'(1);

    fill_row = mem_rdata_i;
    fill_row[victim_q*WAY_W +: STAMP_BITS]             = clock_v;
    fill_row[victim_q*WAY_W + STAMP_BITS +: TAG_W]     = tag_cur;
    fill_row[victim_q*WAY_W + STAMP_BITS + TAG_W]      = !kind_q;
    fill_row[victim_q*WAY_W + STAMP_BITS + TAG_W + 1]  = 1'b1;
    fill_row[WAYS*WAY_W +: STAMP_BITS]                 = clock_v + STAMP_BITS'(1);

    clr_row = '0;
    clr_row[WAYS*WAY_W +: STAMP_BITS] = STAMP_BITS'(1);
  end

  // memory port
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = set_cur;
    mem_wdata_o = hit_row;
    if (cmd_i.clr_wr) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = clr_q;
      mem_wdata_o = clr_row;
    end else if (cmd_i.eval && any_hit) begin
      mem_we_o    = 1'b1;
    end else if (cmd_i.fill_wr) begin
      mem_we_o    = 1'b1;
      mem_wdata_o = fill_row;
    end
  end
  assign mem_re_o    = cmd_i.mem_rd;
  assign mem_raddr_o = set_cur;

  // access split
  assign len7     = (in_item_i.bytes > 7'(LINE_BYTES)) ? 7'(LINE_BYTES) : in_item_i.bytes;
  assign off7     = 7'(in_item_i.addr & OFF_MASK);
  assign sum8     = {1'b0, off7} + {1'b0, len7};
  assign split_in = sum8 > 8'(LINE_BYTES);
  assign first7   = 7'(LINE_BYTES) - off7;

  assign wb_addr  = (64'(tag_a[victim_q]) << (S + B)) | (64'(set_cur) << B);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      if (cmd_i.clr_wr) clr_q <= clr_q + SET_W'(1);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q      <= in_item_i.kind;
      part_addr_q <= in_item_i.addr;
      part_len_q  <= split_in ? first7 : len7;
      addr2_q     <= in_item_i.addr - {57'd0, off7} + 64'(LINE_BYTES);
      len2_q      <= len7 - first7;
      split_q     <= split_in;
      part_q      <= 1'b0;
      hit_acc_q   <= 1'b1;
    end
    if (cmd_i.next_part) begin
      part_addr_q <= addr2_q;
      part_len_q  <= len2_q;
      part_q      <= 1'b1;
    end
    if (cmd_i.eval) hit_acc_q <= hit_acc_q && any_hit;
    if (cmd_i.emit && cmd_i.emit_kind == OK_FETCH) begin
      scan_q <= WIDX_W'(1);
      min_q  <= '0;
    end
    if (cmd_i.scan_step) begin
      if (stamp_a[scan_q] < stamp_a[min_q]) min_q <= scan_q;
      scan_q <= scan_q + WIDX_W'(1);
    end
    if (cmd_i.vic_latch) victim_q <= vic_sel;
    if (cmd_i.emit) begin
      out_q.out_kind <= cmd_i.emit_kind;
      out_q.hit      <= 1'b0;
      out_q.last     <= 1'b0;
      unique case (cmd_i.emit_kind)
        OK_FETCH, OK_WT: begin
          out_q.lower_addr  <= part_addr_q;
          out_q.lower_bytes <= part_len_q;
        end
        OK_WB: begin
          out_q.lower_addr  <= wb_addr;
          out_q.lower_bytes <= 7'(LINE_BYTES);
        end
        OK_DONE: begin
          out_q.lower_addr  <= '0;
          out_q.lower_bytes <= '0;
          out_q.hit         <= hit_acc_q;
          out_q.last        <= 1'b1;
        end
        default: out_q.lower_addr <= '0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    stat_o.clr_last     = (clr_q == SET_W'(NSETS - 1));
    stat_o.out_free     = out_free;
    stat_o.is_hit       = any_hit;
    stat_o.is_read      = kind_q;
    stat_o.wb_mode      = policy_q;
    stat_o.need_scan    = !any_inv && (WAYS > 1);
    stat_o.scan_last    = (scan_q == WIDX_W'(WAYS - 1));
    stat_o.victim_dirty = dirty_v[vic_sel];
    stat_o.has_second   = split_q && !part_q;
  end
endmodule

@@ design/set_assoc_cache_lru_controller.sv @@
// sequence: a one-part hit runs accept, row read, evaluate with row update, next part and done; a
// write-through write emits its lower write after evaluate and fetches nothing; a miss adds fetch,
// an lru scan on a full set, victim pick, a writeback of a dirty victim and fill; a line-crossing
// access runs the read, the evaluate and what follows again for its second part
// throughput: one access at a time; output stalls hold each emit state until the output is free
// reset: asynchronous active low, then a clearing pass over every set row, ready low
module set_assoc_cache_lru_controller #(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sacl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sacl_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);
  import sacl_pkg::*;

  // address split: b offset bits, s set bits, the rest is tag
  localparam int B      = $clog2(LINE_BYTES + 1) - 1;
  localparam int S      = $clog2(SETS + 1) - 1;
  localparam int NSETS  = 1 << S;
  localparam int SET_W  = (S > 0) ? S : 1;
  localparam int TAG_W  = 64 - S - B;
  // one ram row holds a whole set: per way stamp, tag, dirty, valid, then the set clock
  localparam int ROW_W  = WAYS * (STAMP_BITS + TAG_W + 2) + STAMP_BITS;

  ctl_cmd_t         cmd;
  dp_stat_t         stat;
  logic             mem_we, mem_re;
  logic [SET_W-1:0] mem_waddr, mem_raddr;
  logic [ROW_W-1:0] mem_wdata, mem_rdata;

  // sequencer: clear pass, lookup, emits of fetch / write-through / writeback / done
  sacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath holds the access, the lru scan and the output register, so a finished
  // result waits there while the sequencer moves on
  sacl_dp #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // tag, state and stamp store, one row per set
  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NSETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );
endmodule

@@ design/sacl_checker.sv @@
// port-level checks of the cache tag controller, bound to the top level
`include "set_assoc_cache_lru_controller_macros.svh"

module sacl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sacl_pkg::out_item_t out_item_o
);
  import sacl_pkg::*;

  // a pending result holds until its transfer
  `SACL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  // done carries no lower request and closes the access
  `SACL_ASSERT_NOW(a_done_fields, out_valid_o && out_item_o.out_kind == OK_DONE, out_item_o.lower_addr == 64'd0 && out_item_o.lower_bytes == 7'd0 && out_item_o.last)
  // lower requests carry no hit and no last
  `SACL_ASSERT_NOW(a_req_fields, out_valid_o && out_item_o.out_kind != OK_DONE, !out_item_o.hit && !out_item_o.last)
  // one access at a time
  `SACL_ASSERT_NEXT(a_one_access, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind set_assoc_cache_lru_controller sacl_checker u_sacl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
